/* src/fdep_pkg.sv */
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared types and constants for the FAT directory entry parser.
// ----------------------------------------------------------------------------
package fdep_pkg;

    localparam int NameLength   = 128;
    localparam int NameRows     = NameLength / 8;
    localparam int RowW         = $clog2(NameRows);
    localparam int PosW         = $clog2(NameLength);
    localparam int LfnChars     = 13;

    localparam logic [7:0]  BYTE_DELETED = 8'hE5;
    localparam logic [7:0]  BYTE_END     = 8'h00;
    localparam logic [7:0]  BYTE_SPACE   = 8'h20;
    localparam logic [7:0]  BYTE_DOT     = 8'h2E;
    localparam logic [7:0]  ATTR_LFN     = 8'h0F;
    localparam logic [4:0]  ORDER_MASK   = 5'h1F;
    localparam logic [15:0] CHAR_NONE    = 16'hFFFF;
    localparam logic [15:0] MAX_ENTRIES_RESET = 16'd64;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DROP,
        CMD_LFN,
        CMD_EMIT,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        logic                           start;
        cmd_kind_t                      kind;
        logic [LfnChars-1:0][6:0]       lfn_chars;
        logic [PosW-1:0]                lfn_base;
        logic [3:0]                     lfn_cnt;
        logic [63:0]                    short_w0;
        logic [31:0]                    short_w1;
        logic                           short_two;
        logic [31:0]                    cluster;
        logic [31:0]                    size;
        logic [7:0]                     attr;
        logic                           ended;
    } cmd_t;

    // Byte offset of LFN character i inside the 32-byte entry.
    function automatic int lfn_offset(input int i);
        if (i < 5) begin
            return 1 + 2 * i;
        end else if (i < 11) begin
            return 14 + 2 * (i - 5);
        end else begin
            return 28 + 2 * (i - 11);
        end
    endfunction

endpackage

/* src/fdep_front.sv */
// ----------------------------------------------------------------------------
// fdep_front
// Accepts entries, keeps the entry count and end flag, and classifies each
// entry into a command for the back end.
// ----------------------------------------------------------------------------
module fdep_front import fdep_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,
    input  logic [255:0] s_tdata,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         fifo_full,
    output logic         push,
    output cmd_t         cmd
);

    logic [15:0] count_reg, count_next;
    logic        done_reg, done_next;
    logic [15:0] max_reg;

    logic [7:0]  b [32];
    logic [3:0]  nlen;
    logic [1:0]  elen;
    logic        nfound, efound, has_ext;
    logic [7:0]  sn [12];
    logic [6:0]  c  [12];
    logic        zseen;
    logic [8:0]  base;
    logic [3:0]  term_n;
    logic        tfound;
    logic [15:0] ch;
    logic [8:0]  room;
    logic [15:0] count_base;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready && (s_tuser || cmd.kind != CMD_NONE);

    always_comb begin
        for (int k = 0; k < 32; k++) begin
            b[k] = s_tdata[8*k +: 8];
        end

        // Build the 8.3 name.
        nlen = 4'd8; nfound = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!nfound && b[k] == BYTE_SPACE) begin
                nlen = 4'(k); nfound = 1'b1;
            end
        end
        elen = 2'd3; efound = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (!efound && b[8+k] == BYTE_SPACE) begin
                elen = 2'(k); efound = 1'b1;
            end
        end
        has_ext = (b[8] != BYTE_SPACE);
        for (int k = 0; k < 12; k++) begin
            sn[k] = 8'h00;
            if (k < int'(nlen)) begin
                sn[k] = b[k];
            end else if (has_ext && k == int'(nlen)) begin
                sn[k] = BYTE_DOT;
            end else if (has_ext) begin
                for (int x = 0; x < 3; x++) begin
                    if (x < int'(elen) && k == int'(nlen) + 1 + x) begin
                        sn[k] = b[8 + x];
                    end
                end
            end
        end
        zseen = 1'b0;
        for (int k = 0; k < 12; k++) begin
            c[k] = zseen ? 7'd0 : sn[k][6:0];
            if (c[k] == 7'd0) begin
                zseen = 1'b1;
            end
        end

        // Long-name slot and number of characters to store.
        base = 9'(({4'd0, b[0][4:0] & ORDER_MASK} - 9'd1) * 9'd13);
        term_n = 4'd13; tfound = 1'b0;
        cmd.lfn_chars = '0;
        for (int i = 0; i < LfnChars; i++) begin
            ch = {b[lfn_offset(i) + 1], b[lfn_offset(i)]};
            if (ch == 16'h0000 || ch == CHAR_NONE) begin
                cmd.lfn_chars[i] = 7'd0;
                if (!tfound) begin
                    term_n = 4'(i + 1); tfound = 1'b1;
                end
            end else begin
                cmd.lfn_chars[i] = ch[6:0];
            end
        end
        room = (base >= 9'(NameLength - 1)) ? 9'd0 : 9'(NameLength - 1) - base;
        cmd.lfn_cnt  = (room < {5'd0, term_n}) ? room[3:0] : term_n;
        cmd.lfn_base = base[PosW-1:0];

        cmd.short_w0 = '0;
        for (int k = 0; k < 8; k++) begin
            cmd.short_w0[8*k +: 8] = {1'b0, c[k]};
        end
        cmd.short_w1 = '0;
        for (int k = 0; k < 4; k++) begin
            cmd.short_w1[8*k +: 8] = {1'b0, c[8+k]};
        end
        cmd.short_two = (c[8] != 7'd0);
        cmd.cluster   = {b[21], b[20], b[27], b[26]};
        cmd.size      = {b[31], b[30], b[29], b[28]};
        cmd.attr      = b[11];
        cmd.start     = s_tuser;

        // Classify.
        count_base = s_tuser ? 16'd0 : count_reg;
        count_next = count_base;
        done_next  = s_tuser ? 1'b0 : done_reg;
        cmd.ended  = 1'b0;
        cmd.kind   = CMD_NONE;
        if (!done_next) begin
            if (b[0] == BYTE_END || count_base >= max_reg) begin
                cmd.kind  = CMD_END;
                done_next = 1'b1;
            end else if (b[0] == BYTE_DELETED) begin
                cmd.kind = CMD_DROP;
            end else if (b[11] == ATTR_LFN) begin
                cmd.kind = ((b[0][4:0] & ORDER_MASK) == 5'd0) ? CMD_NONE : CMD_LFN;
            end else if (b[11][3] || sn[0] == BYTE_DOT) begin
                cmd.kind = CMD_DROP;
            end else begin
                cmd.kind   = CMD_EMIT;
                count_next = count_base + 16'd1;
                cmd.ended  = (count_next >= max_reg);
                done_next  = cmd.ended;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            max_reg   <= MAX_ENTRIES_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                count_reg <= count_next;
                done_reg  <= done_next;
            end
        end
    end

endmodule

/* src/fdep_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// fdep_cmd_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module fdep_cmd_fifo import fdep_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t rd_cmd
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* src/fdep_back.sv */
// ----------------------------------------------------------------------------
// fdep_back
// Executes commands: writes the long-name store and emits name chunks and end notices.
// ----------------------------------------------------------------------------
module fdep_back import fdep_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         empty,
    input  cmd_t         rd_cmd,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LFN_WR,
        ST_EMIT_LONG,
        ST_EMIT_SHORT
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [55:0]         rows_reg [NameRows];
    logic [55:0]         rows_next [NameRows];
    logic [NameRows-1:0] valid_reg, valid_next;
    logic                pend_reg, pend_next;
    logic [3:0]          k_reg, k_next;
    logic [RowW-1:0]     ri_reg, ri_next;

    logic                tvalid_reg, tvalid_next;
    logic [143:0]        tdata_reg, tdata_next;
    logic [1:0]          tuser_reg, tuser_next;
    logic                tlast_reg, tlast_next;

    logic                out_free;
    logic [NameRows-1:0] head;
    logic [PosW-1:0]     pos;
    logic [55:0]         row;
    logic [63:0]         word;
    logic                zseen, last;

    assign out_free = !tvalid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !empty && out_free;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

    always_comb begin
        for (int r = 0; r < NameRows; r++) begin
            head[r] = valid_reg[r] && (rows_reg[r][6:0] != 7'd0);
        end
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        rows_next   = rows_reg;
        valid_next  = valid_reg;
        pend_next   = pend_reg;
        k_next      = k_reg;
        ri_next     = ri_reg;
        tvalid_next = tvalid_reg && !m_tready;
        tdata_next  = tdata_reg;
        tuser_next  = tuser_reg;
        tlast_next  = tlast_reg;
        pos         = cmd_reg.lfn_base + PosW'(k_reg);
        row         = valid_reg[ri_reg] ? rows_reg[ri_reg] : '0;
        word        = '0;
        zseen       = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (row[7*j +: 7] == 7'd0) begin
                zseen = 1'b1;
            end
            if (!zseen) begin
                word[8*j +: 8] = {1'b0, row[7*j +: 7]};
            end
        end
        last = zseen || (ri_reg == RowW'(NameRows - 1)) || !head[RowW'(ri_reg + 1'b1)];

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    cmd_next = rd_cmd;
                    k_next   = '0;
                    ri_next  = '0;
                    if (rd_cmd.start) begin
                        valid_next = '0;
                        pend_next  = 1'b0;
                    end
                    case (rd_cmd.kind)
                        CMD_DROP: begin
                            valid_next = '0;
                            pend_next  = 1'b0;
                        end
                        CMD_LFN: begin
                            if (rd_cmd.lfn_cnt == 4'd0) begin
                                pend_next = 1'b1;
                            end else begin
                                state_next = ST_LFN_WR;
                            end
                        end
                        CMD_EMIT: begin
                            state_next = (pend_reg && !rd_cmd.start) ? ST_EMIT_LONG
                                                                     : ST_EMIT_SHORT;
                        end
                        CMD_END: begin
                            tvalid_next = 1'b1;
                            tdata_next  = '0;
                            tuser_next  = 2'b10;
                            tlast_next  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LFN_WR: begin
                // Write one character; a fresh row starts from zeros.
                if (!valid_reg[pos[PosW-1:3]]) begin
                    rows_next[pos[PosW-1:3]] = '0;
                end
                rows_next[pos[PosW-1:3]][7*pos[2:0] +: 7] = cmd_reg.lfn_chars[k_reg];
                valid_next[pos[PosW-1:3]] = 1'b1;
                k_next = k_reg + 4'd1;
                if (k_next == cmd_reg.lfn_cnt) begin
                    pend_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_LONG, ST_EMIT_SHORT: begin
                if (out_free) begin
                    if (state_reg == ST_EMIT_SHORT) begin
                        word = (ri_reg == '0) ? cmd_reg.short_w0 : {32'd0, cmd_reg.short_w1};
                        last = (ri_reg != '0) || !cmd_reg.short_two;
                    end
                    tvalid_next = 1'b1;
                    tdata_next  = {4'd0, cmd_reg.attr, cmd_reg.size, cmd_reg.cluster,
                                   4'(ri_reg), word};
                    tuser_next  = {cmd_reg.ended, cmd_reg.attr[4]};
                    tlast_next  = last;
                    ri_next     = ri_reg + 1'b1;
                    if (last) begin
                        valid_next = '0;
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        rows_reg  <= rows_next;
        k_reg     <= k_next;
        ri_reg    <= ri_next;
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            pend_reg   <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            pend_reg   <= pend_next;
            tvalid_reg <= tvalid_next;
        end
    end

endmodule

/* src/fat_directory_entry_parser_unit.sv */
// ----------------------------------------------------------------------------
// fat_directory_entry_parser_unit
// FAT directory entry parser: raw 32-byte entries in, name chunk records out.
// ----------------------------------------------------------------------------
// One input beat carries one 32-byte directory entry. The front end classifies
// it in the accept cycle and queues a command (two deep); the back end then
// works it off. A long-name entry writes n characters (up to 13) into the name
// store, one per cycle through its single write port, and a listed entry emits
// c 8-character output chunks (1 to 16), one per output beat while m_tready is
// high. An ignored entry (a long-name entry of order 0, or any entry after the
// end) is not queued at all unless it starts a new directory.
// No clearing pass is needed after reset: the name store has per-row valid
// bits. Write max_entries only while the block is idle.
module fat_directory_entry_parser_unit import fdep_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: max_entries
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    // entry input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // entry_bytes_0_7, _8_15, _16_23, _24_31
    input  logic         s_tuser,   // start_directory
    // record output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // name_chars, chunk_index, cluster,
                                    // size, attributes, 4 zero bits
    output logic [1:0]   m_tuser,   // is_directory, directory_ended
    output logic         m_tlast    // last_of_record
);

    cmd_t front_cmd, fifo_cmd;
    logic push, pop, full, empty;

    // Classify entries and track count and end state.
    fdep_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fifo_full   (full),
        .push        (push),
        .cmd         (front_cmd)
    );

    // Decouple the two halves.
    fdep_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (front_cmd),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_cmd  (fifo_cmd)
    );

    // Hold the name store and emit records.
    fdep_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .rd_cmd   (fifo_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
